/* rtl/core/msmth_pkg.sv */
`timescale 1ns / 1ps

package msmth_pkg;

   // one motion field on the bus (Q10.6 shifts, Q2.13 angle)
   localparam int FIELD_W = 16;
   // trajectory sums wrap at this width
   localparam int CUM_W = 32;
   // x, y, angle
   localparam int LANES = 3;
   // fast-motion limit after reset
   localparam logic [FIELD_W-1:0] THR_RESET = 16'd1920;

endpackage

/* rtl/core/motion_trajectory_smoother_core.sv */
`timescale 1ns / 1ps

// Trajectory smoother for video stabilization. Each req beat carries one
// frame-to-frame motion estimate (x/y shift Q10.6, rotation Q2.13); frames
// whose shift magnitude exceeds csr_wdata's limit are flagged fast and their
// shifts are zeroed. Running sums form the trajectory, which is averaged over
// a centered window of RADIUS frames each side (cut short at stream ends),
// and each rsp beat carries motion + (smoothed - raw trajectory), saturated.
// Results trail their input by RADIUS frames; the req beat with tlast set
// flushes all pending frames, the final one with rsp_tlast, and the stream
// state then starts over. Each result is built from one trajectory-memory read
// per window entry (cnt = window length, up to 2*RADIUS+1) and a bit-serial
// divide by cnt; a flush produces one such result per pending frame. A result
// waiting in the rsp register does not block the next req beat. No clearing
// pass is needed: only ring entries written in the current stream are ever
// read.
module motion_trajectory_smoother_core import msmth_pkg::*; #(
   parameter int RADIUS = 30
) (
   input  logic                   clock,
   input  logic                   reset,
   // config: motion_threshold
   input  logic                   csr_we,
   input  logic [FIELD_W-1:0]     csr_wdata,
   // req: tdata = shift_x[15:0], shift_y[31:16], rotation[47:32]
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [3*FIELD_W-1:0]   req_tdata,
   input  logic                   req_tlast,   // last_frame
   // rsp: tdata = corrected_shift_x[15:0], corrected_shift_y[31:16],
   //      corrected_rotation[47:32]
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [3*FIELD_W-1:0]   rsp_tdata,
   output logic                   rsp_tuser,   // fast_motion
   output logic                   rsp_tlast    // last_result
);

   localparam int WIN   = 2 * RADIUS + 1;
   localparam int PTR_W = $clog2(WIN);
   localparam int CNT_W = $clog2(WIN + 1);
   localparam int IDX_W = CNT_W + 1;
   localparam int SUM_W = CUM_W + CNT_W;
   localparam logic signed [SUM_W+1:0] SAT_HI = (SUM_W+2)'(2**(FIELD_W-1) - 1);
   localparam logic signed [SUM_W+1:0] SAT_LO = -SAT_HI - 1;

   typedef struct packed {
      logic               fast;
      logic [FIELD_W-1:0] a;
      logic [FIELD_W-1:0] y;
      logic [FIELD_W-1:0] x;
   } motion_type;

   typedef enum logic [2:0] {
      S_IDLE, S_UPD, S_EMIT, S_CENTER, S_ACC, S_DSTART, S_DWAIT, S_OUT
   } state_type;

   state_type            state_in, state_ff;
   logic [FIELD_W-1:0]   thr_in, thr_ff;
   logic [FIELD_W-1:0]   in_x_in, in_x_ff, in_y_in, in_y_ff, in_a_in, in_a_ff;
   logic                 last_in, last_ff;
   logic [CUM_W-1:0]     cum_in [LANES];
   logic [CUM_W-1:0]     cum_ff [LANES];
   logic [PTR_W-1:0]     wr_in, wr_ff;
   logic [CNT_W-1:0]     fill_in, fill_ff, pend_in, pend_ff;
   logic [PTR_W-1:0]     pos_in, pos_ff, j_in, j_ff;
   logic [CNT_W-1:0]     past_in, past_ff, cnt_in, cnt_ff, left_in, left_ff;
   logic                 elast_in, elast_ff;
   logic [CUM_W-1:0]     center_in [LANES];
   logic [CUM_W-1:0]     center_ff [LANES];
   motion_type           motion_in, motion_ff;
   logic signed [SUM_W-1:0] sum_in [LANES];
   logic signed [SUM_W-1:0] sum_ff [LANES];
   logic                 rsp_valid_in, rsp_valid_ff;
   logic [3*FIELD_W-1:0] rsp_data_in, rsp_data_ff;
   logic                 rsp_user_in, rsp_user_ff, rsp_last_in, rsp_last_ff;

   // ring memories
   logic [LANES*CUM_W-1:0] traj_mem [WIN];
   motion_type             mot_mem [WIN];
   logic [LANES*CUM_W-1:0] traj_q_ff;
   motion_type             mot_q_ff;
   logic                   mem_we;
   logic [LANES*CUM_W-1:0] traj_wdata;
   motion_type             mot_wdata;
   logic [PTR_W-1:0]       rd_addr;

   logic                   accept, fast, div_start, div_done;
   logic signed [SUM_W:0]  quot [LANES];
   logic [FIELD_W-1:0]     mx, my;
   logic [CUM_W-1:0]       dlane [LANES];
   logic [FIELD_W-1:0]     mlane [LANES];
   logic [FIELD_W-1:0]     corr [LANES];
   logic [IDX_W-1:0]       pos_w, j0_w;
   logic [PTR_W-1:0]       pos_c, j0_c;
   logic [CNT_W-1:0]       past_c, fut_c;

   function automatic logic [PTR_W-1:0] ring_inc(input logic [PTR_W-1:0] p);
      ring_inc = (p == PTR_W'(WIN - 1)) ? '0 : p + 1'b1;
   endfunction

   function automatic logic [FIELD_W-1:0] sat_field(input logic signed [SUM_W+1:0] v);
      if (v > SAT_HI)      sat_field = SAT_HI[FIELD_W-1:0];
      else if (v < SAT_LO) sat_field = SAT_LO[FIELD_W-1:0];
      else                 sat_field = v[FIELD_W-1:0];
   endfunction

   assign accept     = req_tvalid && req_tready;
   assign req_tready = (state_ff == S_IDLE);

   msmth_gate u_gate (
      .clock     (clock),
      .load      (accept),
      .shift_x   (req_tdata[FIELD_W-1:0]),
      .shift_y   (req_tdata[2*FIELD_W-1:FIELD_W]),
      .threshold (thr_ff),
      .fast      (fast)
   );

   msmth_div #(.SUM_W(SUM_W), .CNT_W(CNT_W)) u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .cnt   (cnt_ff),
      .sum   (sum_ff),
      .done  (div_done),
      .quot  (quot)
   );

   // fast frames keep only their rotation
   assign mx = fast ? '0 : in_x_ff;
   assign my = fast ? '0 : in_y_ff;

   // oldest pending frame: wr - pend, mod WIN
   assign pos_w = IDX_W'(wr_ff) + IDX_W'(WIN) - IDX_W'(pend_ff);
   assign pos_c = (pos_w >= IDX_W'(WIN)) ? PTR_W'(pos_w - IDX_W'(WIN)) : PTR_W'(pos_w);
   // first window entry: pos - past, mod WIN
   assign j0_w  = IDX_W'(pos_ff) + IDX_W'(WIN) - IDX_W'(past_ff);
   assign j0_c  = (j0_w >= IDX_W'(WIN)) ? PTR_W'(j0_w - IDX_W'(WIN)) : PTR_W'(j0_w);

   assign past_c = ((fill_ff - pend_ff) > CNT_W'(RADIUS)) ? CNT_W'(RADIUS)
                                                          : fill_ff - pend_ff;
   assign fut_c  = ((pend_ff - 1'b1) > CNT_W'(RADIUS)) ? CNT_W'(RADIUS)
                                                       : pend_ff - 1'b1;

   assign mlane[0] = motion_ff.x;
   assign mlane[1] = motion_ff.y;
   assign mlane[2] = motion_ff.a;

   always_comb begin
      for (int l = 0; l < LANES; l++) begin
         // per-entry wrapped difference from the center trajectory
         dlane[l] = traj_q_ff[l*CUM_W +: CUM_W] - center_ff[l];
         corr[l]  = sat_field($signed({{(SUM_W+2-FIELD_W){mlane[l][FIELD_W-1]}}, mlane[l]})
                              + $signed({quot[l][SUM_W], quot[l]}));
      end
   end

   always_comb begin
      state_in     = state_ff;
      thr_in       = csr_we ? csr_wdata : thr_ff;
      in_x_in      = in_x_ff;
      in_y_in      = in_y_ff;
      in_a_in      = in_a_ff;
      last_in      = last_ff;
      wr_in        = wr_ff;
      fill_in      = fill_ff;
      pend_in      = pend_ff;
      pos_in       = pos_ff;
      j_in         = j_ff;
      past_in      = past_ff;
      cnt_in       = cnt_ff;
      left_in      = left_ff;
      elast_in     = elast_ff;
      motion_in    = motion_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      rsp_user_in  = rsp_user_ff;
      rsp_last_in  = rsp_last_ff;
      for (int l = 0; l < LANES; l++) begin
         cum_in[l]    = cum_ff[l];
         center_in[l] = center_ff[l];
         sum_in[l]    = sum_ff[l];
      end
      mem_we     = 1'b0;
      traj_wdata = '0;
      mot_wdata  = '0;
      rd_addr    = j_ff;
      div_start  = 1'b0;

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               in_x_in  = req_tdata[FIELD_W-1:0];
               in_y_in  = req_tdata[2*FIELD_W-1:FIELD_W];
               in_a_in  = req_tdata[3*FIELD_W-1:2*FIELD_W];
               last_in  = req_tlast;
               state_in = S_UPD;
            end
         end
         S_UPD: begin
            cum_in[0] = cum_ff[0] + {{(CUM_W-FIELD_W){mx[FIELD_W-1]}}, mx};
            cum_in[1] = cum_ff[1] + {{(CUM_W-FIELD_W){my[FIELD_W-1]}}, my};
            cum_in[2] = cum_ff[2] + {{(CUM_W-FIELD_W){in_a_ff[FIELD_W-1]}}, in_a_ff};
            mem_we      = 1'b1;
            traj_wdata  = {cum_in[2], cum_in[1], cum_in[0]};
            mot_wdata.fast = fast;
            mot_wdata.x    = mx;
            mot_wdata.y    = my;
            mot_wdata.a    = in_a_ff;
            wr_in   = ring_inc(wr_ff);
            fill_in = (fill_ff < CNT_W'(WIN)) ? fill_ff + 1'b1 : fill_ff;
            pend_in = (pend_ff < CNT_W'(WIN)) ? pend_ff + 1'b1 : pend_ff;
            state_in = S_EMIT;
         end
         S_EMIT: begin
            // steady flow emits once RADIUS later frames are in; flush emits all
            rd_addr = pos_c;
            if ((last_ff || pend_ff > CNT_W'(RADIUS)) && pend_ff != '0) begin
               pos_in   = pos_c;
               past_in  = past_c;
               cnt_in   = past_c + fut_c + 1'b1;
               elast_in = last_ff && (pend_ff == CNT_W'(1));
               state_in = S_CENTER;
            end else begin
               state_in = S_IDLE;
            end
         end
         S_CENTER: begin
            for (int l = 0; l < LANES; l++) begin
               center_in[l] = traj_q_ff[l*CUM_W +: CUM_W];
               sum_in[l]    = '0;
            end
            motion_in = mot_q_ff;
            rd_addr   = j0_c;
            j_in      = ring_inc(j0_c);
            left_in   = cnt_ff;
            state_in  = S_ACC;
         end
         S_ACC: begin
            for (int l = 0; l < LANES; l++) begin
               sum_in[l] = sum_ff[l] + $signed({{CNT_W{dlane[l][CUM_W-1]}}, dlane[l]});
            end
            rd_addr = j_ff;
            j_in    = ring_inc(j_ff);
            left_in = left_ff - 1'b1;
            if (left_ff == CNT_W'(1)) begin
               state_in = S_DSTART;
            end
         end
         S_DSTART: begin
            div_start = 1'b1;
            state_in  = S_DWAIT;
         end
         S_DWAIT: begin
            if (div_done) begin
               state_in = S_OUT;
            end
         end
         S_OUT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {corr[2], corr[1], corr[0]};
               rsp_user_in  = motion_ff.fast;
               rsp_last_in  = elast_ff;
               if (elast_ff) begin
                  // end of stream: back to a clean start
                  for (int l = 0; l < LANES; l++) begin
                     cum_in[l] = '0;
                  end
                  wr_in    = '0;
                  fill_in  = '0;
                  pend_in  = '0;
                  state_in = S_IDLE;
               end else begin
                  pend_in  = pend_ff - 1'b1;
                  state_in = S_EMIT;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         thr_ff       <= THR_RESET;
         wr_ff        <= '0;
         fill_ff      <= '0;
         pend_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         for (int l = 0; l < LANES; l++) begin
            cum_ff[l] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         thr_ff       <= thr_in;
         wr_ff        <= wr_in;
         fill_ff      <= fill_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
         for (int l = 0; l < LANES; l++) begin
            cum_ff[l] <= cum_in[l];
         end
      end
      in_x_ff     <= in_x_in;
      in_y_ff     <= in_y_in;
      in_a_ff     <= in_a_in;
      last_ff     <= last_in;
      pos_ff      <= pos_in;
      j_ff        <= j_in;
      past_ff     <= past_in;
      cnt_ff      <= cnt_in;
      left_ff     <= left_in;
      elast_ff    <= elast_in;
      motion_ff   <= motion_in;
      rsp_data_ff <= rsp_data_in;
      rsp_user_ff <= rsp_user_in;
      rsp_last_ff <= rsp_last_in;
      for (int l = 0; l < LANES; l++) begin
         center_ff[l] <= center_in[l];
         sum_ff[l]    <= sum_in[l];
      end
   end

   // ring memories: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (mem_we) begin
         traj_mem[wr_ff] <= traj_wdata;
         mot_mem[wr_ff]  <= mot_wdata;
      end
      traj_q_ff <= traj_mem[rd_addr];
      mot_q_ff  <= mot_mem[rd_addr];
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule

/* rtl/core/msmth_gate.sv */
`timescale 1ns / 1ps

// Fast-motion test: squared shift magnitude against squared limit.
module msmth_gate import msmth_pkg::*; (
   input  logic                      clock,
   input  logic                      load,
   input  logic signed [FIELD_W-1:0] shift_x,
   input  logic signed [FIELD_W-1:0] shift_y,
   input  logic        [FIELD_W-1:0] threshold,
   output logic                      fast
);

   logic signed [2*FIELD_W-1:0] xsq_in, ysq_in;
   logic signed [2*FIELD_W-1:0] xsq_ff, ysq_ff;
   logic        [2*FIELD_W-1:0] thr_sq_in, thr_sq_ff;
   logic        [2*FIELD_W:0]   mag;

   assign xsq_in    = shift_x * shift_x;
   assign ysq_in    = shift_y * shift_y;
   assign thr_sq_in = threshold * threshold;

   always_ff @(posedge clock) begin
      if (load) begin
         xsq_ff <= xsq_in;
         ysq_ff <= ysq_in;
      end
      thr_sq_ff <= thr_sq_in;
   end

   // squares are never negative, so plain unsigned add
   assign mag  = {1'b0, xsq_ff} + {1'b0, ysq_ff};
   assign fast = mag > {1'b0, thr_sq_ff};

endmodule

/* rtl/core/msmth_div.sv */
`timescale 1ns / 1ps

// Three-lane restoring divider, one quotient bit per cycle.
// Rounds to nearest, ties away from zero.
module msmth_div import msmth_pkg::*; #(
   parameter int SUM_W = 38,
   parameter int CNT_W = 6
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  logic        [CNT_W-1:0] cnt,
   input  logic signed [SUM_W-1:0] sum  [LANES],
   output logic                    done,
   output logic signed [SUM_W:0]   quot [LANES]
);

   localparam int STEP_W = $clog2(SUM_W);

   logic                    busy_in, busy_ff;
   logic                    done_in, done_ff;
   logic [STEP_W-1:0]       step_in, step_ff;
   logic [CNT_W-1:0]        div_in, div_ff;
   logic [SUM_W-1:0]        mag_in [LANES];
   logic [SUM_W-1:0]        mag_ff [LANES];
   logic [CNT_W-1:0]        rem_in [LANES];
   logic [CNT_W-1:0]        rem_ff [LANES];
   logic                    neg_in [LANES];
   logic                    neg_ff [LANES];
   logic signed [SUM_W:0]   quot_in [LANES];
   logic signed [SUM_W:0]   quot_ff [LANES];
   logic [SUM_W-1:0]        abs_v [LANES];
   logic [CNT_W:0]          trial [LANES];
   logic [CNT_W:0]          diff_v [LANES];
   logic                    ge [LANES];

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      div_in  = div_ff;
      for (int l = 0; l < LANES; l++) begin
         mag_in[l]  = mag_ff[l];
         rem_in[l]  = rem_ff[l];
         neg_in[l]  = neg_ff[l];
         quot_in[l] = quot_ff[l];
         abs_v[l]   = sum[l][SUM_W-1] ? SUM_W'(-sum[l]) : SUM_W'(sum[l]);
         trial[l]   = {rem_ff[l], mag_ff[l][SUM_W-1]};
         diff_v[l]  = trial[l] - {1'b0, div_ff};
         ge[l]      = trial[l] >= {1'b0, div_ff};
      end
      if (start) begin
         busy_in = 1'b1;
         step_in = '0;
         div_in  = cnt;
         for (int l = 0; l < LANES; l++) begin
            neg_in[l] = sum[l][SUM_W-1];
            // half the divisor in front gives round-to-nearest
            mag_in[l] = abs_v[l] + SUM_W'(cnt >> 1);
            rem_in[l] = '0;
         end
      end else if (busy_ff) begin
         step_in = step_ff + 1'b1;
         for (int l = 0; l < LANES; l++) begin
            rem_in[l] = ge[l] ? diff_v[l][CNT_W-1:0] : trial[l][CNT_W-1:0];
            mag_in[l] = {mag_ff[l][SUM_W-2:0], ge[l]};
         end
         if (step_ff == STEP_W'(SUM_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
            for (int l = 0; l < LANES; l++) begin
               quot_in[l] = neg_ff[l] ? -$signed({1'b0, mag_in[l]})
                                      : $signed({1'b0, mag_in[l]});
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
      div_ff <= div_in;
      for (int l = 0; l < LANES; l++) begin
         mag_ff[l]  <= mag_in[l];
         rem_ff[l]  <= rem_in[l];
         neg_ff[l]  <= neg_in[l];
         quot_ff[l] <= quot_in[l];
      end
   end

   assign done = done_ff;
   assign quot = quot_ff;

endmodule

/* rtl/core/msmth_checker.sv */
`timescale 1ns / 1ps

module msmth_checker import msmth_pkg::*; (
   input logic                 clock,
   input logic                 reset,
   input logic                 req_tvalid,
   input logic                 req_tready,
   input logic                 rsp_tvalid,
   input logic                 rsp_tready,
   input logic [3*FIELD_W-1:0] rsp_tdata,
   input logic                 rsp_tuser,
   input logic                 rsp_tlast
);

   // stalled rsp beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata)
         && $stable(rsp_tuser) && $stable(rsp_tlast))
      else $error("rsp beat changed while stalled");

   // one item at a time: ready drops after a req beat
   a_one_item: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("req accepted while busy");

   // no result can be produced right after a req beat
   a_no_early_rsp: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !$rose(rsp_tvalid))
      else $error("rsp raised during state update");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("rsp valid after reset");

endmodule

bind motion_trajectory_smoother_core msmth_checker u_msmth_checker (.*);

/* tb/sv/tb.sv */
`timescale 1ns / 1ps

// Smoother testbench: a table of directed frames, then three phases of random
// motion sequences under different threshold settings and idling mixes.
// Every accepted frame goes through a local model of the trajectory window;
// each rsp beat is compared field by field with the oldest predicted beat.
module tb;
   import msmth_pkg::*;

   localparam int RADIUS = 30;
   localparam int WIN = 2 * RADIUS + 1;
   localparam int ITEMS_PER_PHASE = 87;
   // idle settle before a csr write
   localparam int SETTLE_CYCLES = 200;
   localparam int HOLD_CYCLES = 2500;
   localparam int LIMIT = 1000000;
   localparam int N_DIR = 21;

   typedef struct packed {
      logic signed [15:0] cx;
      logic signed [15:0] cy;
      logic signed [15:0] ca;
      logic               fast;
      logic               last_res;
   } smooth_res_t;

   typedef struct packed {
      logic               set_thr;
      logic [15:0]        thr_v;
      logic signed [15:0] sx;
      logic signed [15:0] sy;
      logic signed [15:0] rot;
      logic               last;
      logic               typed;
      smooth_res_t        want;
   } frame_row_t;

   localparam logic [15:0] THR_MAX = 16'hffff;
   localparam logic [15:0] THR_ZERO = 16'h0000;
   localparam logic signed [15:0] S_MIN = 16'sh8000;
   localparam logic signed [15:0] S_MAX = 16'sh7fff;

   // single-frame sequences carry a typed result: window of one, no correction
   frame_row_t dir_rows [N_DIR] = '{
      '{1'b0, THR_RESET, 16'sd100, -16'sd50, 16'sd1234, 1'b1, 1'b1,
        '{16'sd100, -16'sd50, 16'sd1234, 1'b0, 1'b1}},
      // exactly on the limit is not fast
      '{1'b0, THR_RESET, 16'sd1920, 16'sd0, 16'sd0, 1'b1, 1'b1,
        '{16'sd1920, 16'sd0, 16'sd0, 1'b0, 1'b1}},
      '{1'b0, THR_RESET, 16'sd1921, 16'sd0, -16'sd1, 1'b1, 1'b1,
        '{16'sd0, 16'sd0, -16'sd1, 1'b1, 1'b1}},
      '{1'b0, THR_RESET, 16'sd0, -16'sd1921, 16'sd7, 1'b1, 1'b1,
        '{16'sd0, 16'sd0, 16'sd7, 1'b1, 1'b1}},
      '{1'b0, THR_RESET, S_MAX, S_MAX, S_MAX, 1'b1, 1'b1,
        '{16'sd0, 16'sd0, S_MAX, 1'b1, 1'b1}},
      '{1'b0, THR_RESET, S_MIN, S_MIN, S_MIN, 1'b1, 1'b1,
        '{16'sd0, 16'sd0, S_MIN, 1'b1, 1'b1}},
      // widest limit: even full-scale shifts pass
      '{1'b1, THR_MAX, S_MIN, S_MIN, S_MIN, 1'b1, 1'b1,
        '{S_MIN, S_MIN, S_MIN, 1'b0, 1'b1}},
      '{1'b0, THR_MAX, S_MAX, S_MIN, 16'sd0, 1'b1, 1'b1,
        '{S_MAX, S_MIN, 16'sd0, 1'b0, 1'b1}},
      // zero limit: any nonzero shift is fast
      '{1'b1, THR_ZERO, 16'sd0, 16'sd0, 16'sd5, 1'b1, 1'b1,
        '{16'sd0, 16'sd0, 16'sd5, 1'b0, 1'b1}},
      '{1'b0, THR_ZERO, 16'sd1, 16'sd0, 16'sd21845, 1'b1, 1'b1,
        '{16'sd0, 16'sd0, 16'sd21845, 1'b1, 1'b1}},
      '{1'b0, THR_ZERO, 16'sd0, -16'sd1, -16'sd21846, 1'b1, 1'b1,
        '{16'sd0, 16'sd0, -16'sd21846, 1'b1, 1'b1}},
      // full-scale swings, short window at both ends: drives saturation
      '{1'b1, THR_MAX, S_MAX, S_MIN, S_MAX, 1'b0, 1'b0, '0},
      '{1'b0, THR_MAX, S_MAX, S_MIN, S_MAX, 1'b0, 1'b0, '0},
      '{1'b0, THR_MAX, S_MIN, S_MAX, S_MIN, 1'b0, 1'b0, '0},
      '{1'b0, THR_MAX, S_MIN, S_MAX, S_MIN, 1'b0, 1'b0, '0},
      '{1'b0, THR_MAX, S_MAX, S_MIN, S_MAX, 1'b1, 1'b0, '0},
      // mixed short sequence with one fast frame in the middle
      '{1'b1, THR_RESET, 16'sd1000, -16'sd700, 16'sd300, 1'b0, 1'b0, '0},
      '{1'b0, THR_RESET, 16'sd2000, 16'sd0, -16'sd300, 1'b0, 1'b0, '0},
      '{1'b0, THR_RESET, -16'sd500, 16'sd1500, 16'sd100, 1'b0, 1'b0, '0},
      '{1'b0, THR_RESET, 16'sd0, 16'sd0, 16'sd0, 1'b0, 1'b0, '0},
      '{1'b0, THR_RESET, -16'sd1919, 16'sd10, -16'sd8192, 1'b1, 1'b0, '0}
   };

   localparam int TX_IDLE [3] = '{11, 47, 0};
   localparam int RX_IDLE [3] = '{47, 11, 0};

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 csr_we = 1'b0;
   logic [FIELD_W-1:0]   csr_wdata = '0;
   logic                 req_tvalid = 1'b0;
   logic                 req_tready;
   logic [3*FIELD_W-1:0] req_tdata = '0;
   logic                 req_tlast = 1'b0;
   logic                 rsp_tvalid;
   logic                 rsp_tready = 1'b0;
   logic [3*FIELD_W-1:0] rsp_tdata;
   logic                 rsp_tuser;
   logic                 rsp_tlast;

   // model state: trajectory ring, held motion, running sums
   logic [31:0]        traj_x [WIN];
   logic [31:0]        traj_y [WIN];
   logic [31:0]        traj_a [WIN];
   logic signed [15:0] held_x [WIN];
   logic signed [15:0] held_y [WIN];
   logic signed [15:0] held_a [WIN];
   logic               held_fast [WIN];
   logic [31:0]        acc_x = '0;
   logic [31:0]        acc_y = '0;
   logic [31:0]        acc_a = '0;
   int                 win_fill = 0;
   int                 unsent = 0;
   int                 wpos = 0;
   logic [15:0]        limit_thr = THR_RESET;

   smooth_res_t smoothed_new [$];
   smooth_res_t smoothed_due [$];

   int tx_idle_pct = TX_IDLE[0];
   int rx_idle_pct = RX_IDLE[0];
   logic hold_req = 1'b0;
   logic hold_done = 1'b0;
   int hold_left = 0;
   int cycle_cnt = 0;
   int n_fail = 0;
   int n_frames = 0;
   int n_fast = 0;
   int n_seq = 0;
   int n_checked = 0;

   motion_trajectory_smoother_core #(
      .RADIUS(RADIUS)
   ) i_dut (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   always #10 clock = ~clock;

   always @(posedge clock) begin
      cycle_cnt <= cycle_cnt + 1;
      if (cycle_cnt == LIMIT) begin
         $display("%0t ns: timeout, %0d beats still due", $time, smoothed_due.size());
         $display("TB_ERROR");
         $finish;
      end
   end

   // trajectory difference taken as a signed 32-bit quantity, so wrap cancels
   function automatic longint wrap_diff(logic [31:0] p, logic [31:0] q);
      logic [31:0] d;
      d = p - q;
      return longint'($signed(d));
   endfunction

   // nearest, ties away from zero
   function automatic longint round_div(longint s, longint c);
      if (s >= 0) return (s + c / 2) / c;
      return -((-s + c / 2) / c);
   endfunction

   function automatic logic signed [15:0] clamp16(longint v);
      if (v > 32767) return S_MAX;
      if (v < -32768) return S_MIN;
      return 16'(v);
   endfunction

   // corrected motion for ring slot pos over a window of past/fut neighbors
   function automatic smooth_res_t smooth_at(int pos, int past, int fut, logic is_last);
      longint sum_x, sum_y, sum_a, cnt;
      int j;
      smooth_res_t r;
      sum_x = 0;
      sum_y = 0;
      sum_a = 0;
      cnt = past + fut + 1;
      for (int k = -past; k <= fut; k++) begin
         j = (pos + WIN + k) % WIN;
         sum_x += wrap_diff(traj_x[j], traj_x[pos]);
         sum_y += wrap_diff(traj_y[j], traj_y[pos]);
         sum_a += wrap_diff(traj_a[j], traj_a[pos]);
      end
      r.cx = clamp16(longint'(held_x[pos]) + round_div(sum_x, cnt));
      r.cy = clamp16(longint'(held_y[pos]) + round_div(sum_y, cnt));
      r.ca = clamp16(longint'(held_a[pos]) + round_div(sum_a, cnt));
      r.fast = held_fast[pos];
      r.last_res = is_last;
      return r;
   endfunction

   // one accepted frame: threshold, accumulate, emit what is now due
   function automatic void smooth_frame(logic signed [15:0] fx, logic signed [15:0] fy,
                                        logic signed [15:0] fa, logic fl);
      longint mag, lim;
      logic fast;
      int pos, past, fut;
      mag = longint'(fx) * fx + longint'(fy) * fy;
      lim = longint'(limit_thr) * longint'(limit_thr);
      fast = (mag > lim);
      if (fast) begin
         fx = '0;
         fy = '0;
         n_fast++;
      end
      acc_x = acc_x + 32'(fx);
      acc_y = acc_y + 32'(fy);
      acc_a = acc_a + 32'(fa);
      traj_x[wpos] = acc_x;
      traj_y[wpos] = acc_y;
      traj_a[wpos] = acc_a;
      held_x[wpos] = fx;
      held_y[wpos] = fy;
      held_a[wpos] = fa;
      held_fast[wpos] = fast;
      wpos = (wpos + 1) % WIN;
      if (win_fill < WIN) win_fill++;
      if (unsent < WIN) unsent++;
      if (!fl) begin
         // steady flow: oldest frame goes once RADIUS later frames are in
         if (unsent > RADIUS) begin
            pos = (wpos + WIN - unsent) % WIN;
            past = win_fill - unsent;
            if (past > RADIUS) past = RADIUS;
            smoothed_new.push_back(smooth_at(pos, past, unsent - 1, 1'b0));
            unsent--;
         end
      end else begin
         // flush everything pending, window cut short at the tail
         while (unsent > 0) begin
            pos = (wpos + WIN - unsent) % WIN;
            past = win_fill - unsent;
            fut = unsent - 1;
            if (past > RADIUS) past = RADIUS;
            if (fut > RADIUS) fut = RADIUS;
            smoothed_new.push_back(smooth_at(pos, past, fut, unsent == 1));
            unsent--;
         end
         acc_x = '0;
         acc_y = '0;
         acc_a = '0;
         win_fill = 0;
         wpos = 0;
      end
   endfunction

   // shift or angle: mostly near the limit, some full range, some corners
   function automatic logic signed [15:0] pick_shift(int span);
      int r;
      r = $urandom_range(0, 99);
      if (r < 10) begin
         case ($urandom_range(0, 3))
            0: return S_MIN;
            1: return S_MAX;
            2: return 16'sd0;
            default: return -16'sd1;
         endcase
      end
      if (r < 25) return 16'($urandom);
      return 16'(int'($urandom_range(0, 2 * span)) - span);
   endfunction

   // called at a rising edge; returns at the edge where the beat is taken
   task automatic offer_frame(input logic signed [15:0] fx, input logic signed [15:0] fy,
                              input logic signed [15:0] fa, input logic fl,
                              input logic use_want, input smooth_res_t want);
      int gap;
      gap = 0;
      while (gap < 20 && $urandom_range(0, 99) < tx_idle_pct) gap++;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {fa, fy, fx};
      req_tlast <= fl;
      do @(posedge clock); while (!req_tready);
      n_frames++;
      smooth_frame(fx, fy, fa, fl);
      if (use_want) begin
         smoothed_due.push_back(want);
         smoothed_new.delete();
      end
      while (smoothed_new.size() > 0) smoothed_due.push_back(smoothed_new.pop_front());
   endtask

   // csr writes only with the block drained and quiet
   task automatic settle_and_write(input logic [15:0] v);
      req_tvalid <= 1'b0;
      while (smoothed_due.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_we <= 1'b1;
      csr_wdata <= v;
      @(posedge clock);
      csr_we <= 1'b0;
      limit_thr = v;
   endtask

   // receiver: random stalls, plus one long hold-off to back up the block
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_left > 0) begin
         rsp_tready <= 1'b0;
         hold_left <= hold_left - 1;
      end else if (hold_req && !hold_done) begin
         rsp_tready <= 1'b0;
         hold_left <= HOLD_CYCLES;
         hold_done <= 1'b1;
      end else begin
         rsp_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
      end
   end

   function automatic bit field_ok(string name, logic signed [15:0] want_v,
                                   logic signed [15:0] seen_v);
      if (seen_v === want_v) return 1'b1;
      $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, name, want_v, seen_v);
      return 1'b0;
   endfunction

   // rsp beat check against the oldest due result
   always @(posedge clock) begin
      smooth_res_t want;
      if (!reset && rsp_tvalid === 1'b1 && rsp_tready) begin
         if (smoothed_due.size() == 0) begin
            $display("%0t ns: rsp beat with nothing due, tdata %h", $time, rsp_tdata);
            n_fail++;
         end else begin
            want = smoothed_due.pop_front();
            n_checked++;
            if (!(field_ok("corrected_shift_x", want.cx, rsp_tdata[15:0])
                  & field_ok("corrected_shift_y", want.cy, rsp_tdata[31:16])
                  & field_ok("corrected_rotation", want.ca, rsp_tdata[47:32])
                  & field_ok("fast_motion", {15'd0, want.fast}, {15'd0, rsp_tuser})
                  & field_ok("last_result", {15'd0, want.last_res}, {15'd0, rsp_tlast})))
               n_fail++;
         end
      end
   end

   initial begin
      int left, len, span;
      logic [15:0] thr_pick;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (dir_rows[i]) begin
         if (dir_rows[i].set_thr) settle_and_write(dir_rows[i].thr_v);
         offer_frame(dir_rows[i].sx, dir_rows[i].sy, dir_rows[i].rot, dir_rows[i].last,
                     dir_rows[i].typed, dir_rows[i].want);
         if (dir_rows[i].last) n_seq++;
      end

      for (int p = 0; p < 3; p++) begin
         case (p)
            0: thr_pick = 16'($urandom_range(300, 3000));
            1: thr_pick = 16'($urandom_range(1000, 40000));
            default: thr_pick = THR_RESET;
         endcase
         settle_and_write(thr_pick);
         tx_idle_pct = TX_IDLE[p];
         rx_idle_pct <= RX_IDLE[p];
         span = int'(thr_pick) * 3 / 2 + 64;
         if (span > 32767) span = 32767;
         left = ITEMS_PER_PHASE;
         // one sequence long enough to fill the window, then short ones
         len = $urandom_range(66, 75);
         while (left > 0) begin
            if (len > left) len = left;
            for (int k = 1; k <= len; k++) begin
               if (p == 2 && k == 40) hold_req <= 1'b1;
               offer_frame(pick_shift(span), pick_shift(span), pick_shift(8192), k == len,
                           1'b0, '0);
            end
            left -= len;
            n_seq++;
            len = $urandom_range(1, 12);
         end
      end

      req_tvalid <= 1'b0;
      while (smoothed_due.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      n_fail += smoothed_due.size();

      $display("%0d motion frames in %0d sequences (%0d fast), %0d smoothed beats checked",
               n_frames, n_seq, n_fast, n_checked);
      $display("limits 0, reset, full scale and random; idling both ways; one long rsp stall");
      if (n_fail == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule

/* motion_trajectory_smoother_core.f */
rtl/core/msmth_pkg.sv
rtl/core/msmth_gate.sv
rtl/core/msmth_div.sv
rtl/core/motion_trajectory_smoother_core.sv
rtl/core/msmth_checker.sv
tb/sv/tb.sv
